@@ hw/rtl/osd_pkg.sv @@
// Shared types, codes and default sizes for the ordered set difference unit.
package osd_pkg;

    // Width of the value fields on the request and result channels.
    localparam int VALUE_PORT_W = 32;

    // Defaults for the top-level parameters.
    localparam int EXCLUDE_DEPTH_DEF = 64;
    localparam int PASSED_DEPTH_DEF  = 64;
    localparam int VALUE_WIDTH_DEF   = 32;

    // Request codes; code three is unused and gives an empty result.
    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_TEST  = 2'd2
    } t_req_type;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_EX,
        ST_SCAN_PA,
        ST_APPEND,
        ST_FINISH
    } t_state;

endpackage

@@ hw/rtl/osd_req_if.sv @@
// Request channel interface: valid/ready handshake with request type and value.
interface osd_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        req_type;
    logic [osd_pkg::VALUE_PORT_W-1:0]  value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

@@ hw/rtl/osd_res_if.sv @@
// Result channel interface: valid/ready handshake with kept flag, value and overflow.
interface osd_res_if;
    logic                              valid;
    logic                              ready;
    logic                              kept;
    logic [osd_pkg::VALUE_PORT_W-1:0]  out_value;
    logic                              overflow;

    modport source (output valid, output kept, output out_value, output overflow,
                    input ready);
    modport sink   (input valid, input kept, input out_value, input overflow,
                    output ready);
endinterface

@@ hw/rtl/ordered_set_difference_unit.sv @@
// Top level of the ordered set difference unit: sequencer, two tables and one comparator.
//
//   Channel  Dir  Handshake            Payload
//   i_req    in   valid / ready        req_type[1:0], value[31:0]
//   o_res    out  valid / ready        kept, out_value[31:0], overflow
//
// A clear, a load or an unused request code passes from acceptance through the execute
// state to the finish state, which moves the result into the result register. A test
// scans the excluded and then the passed table up to their current fill counts, so its
// run grows with them; the single comparator scans both tables one entry a cycle.
// A match ends the scan early. Reset clears both fill counts, so no clearing pass runs.
// The next request is taken once the result has been moved into the output register;
// a stalled result holds the sequencer in its final state until the register frees.
module ordered_set_difference_unit #(
    parameter int EXCLUDE_DEPTH = osd_pkg::EXCLUDE_DEPTH_DEF,
    parameter int PASSED_DEPTH  = osd_pkg::PASSED_DEPTH_DEF,
    parameter int VALUE_WIDTH   = osd_pkg::VALUE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    osd_req_if.sink    i_req,
    osd_res_if.source  o_res
);

    // Address and count widths. Counts must be able to hold the depth itself.
    localparam int EAW = (EXCLUDE_DEPTH > 1) ? $clog2(EXCLUDE_DEPTH) : 1;
    localparam int PAW = (PASSED_DEPTH > 1) ? $clog2(PASSED_DEPTH) : 1;
    localparam int ECW = $clog2(EXCLUDE_DEPTH + 1);
    localparam int PCW = $clog2(PASSED_DEPTH + 1);
    localparam int IW  = (ECW > PCW) ? ECW : PCW;
    localparam int OW  = osd_pkg::VALUE_PORT_W;

    // Control state.
    osd_pkg::t_state     r_state, n_state;
    logic [ECW-1:0]      r_ex_cnt, n_ex_cnt;
    logic [PCW-1:0]      r_pa_cnt, n_pa_cnt;
    logic [IW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic                r_o_valid, n_o_valid;

    // Payload state.
    logic [1:0]             r_req, n_req;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic                   r_kept, n_kept;
    logic                   r_ovf, n_ovf;
    logic                   r_o_kept, n_o_kept;
    logic [OW-1:0]          r_o_val, n_o_val;
    logic                   r_o_ovf, n_o_ovf;

    // Table ports.
    logic                   w_ex_we, w_pa_we;
    logic [VALUE_WIDTH-1:0] w_ex_rdata, w_pa_rdata, w_rdata;
    logic                   w_match;

    osd_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (EXCLUDE_DEPTH)
    ) u_ex_ram (
        .i_clk   (i_clk),
        .i_we    (w_ex_we),
        .i_waddr (r_ex_cnt[EAW-1:0]),
        .i_wdata (r_val),
        .i_raddr (r_idx[EAW-1:0]),
        .o_rdata (w_ex_rdata)
    );

    osd_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (PASSED_DEPTH)
    ) u_pa_ram (
        .i_clk   (i_clk),
        .i_we    (w_pa_we),
        .i_waddr (r_pa_cnt[PAW-1:0]),
        .i_wdata (r_val),
        .i_raddr (r_idx[PAW-1:0]),
        .o_rdata (w_pa_rdata)
    );

    // The one comparator is shared by both scans. A pending read is always finished
    // before the scan moves from the excluded table to the passed table, so the
    // state alone selects which table's read data is compared.
    assign w_rdata = (r_state == osd_pkg::ST_SCAN_PA) ? w_pa_rdata : w_ex_rdata;
    assign w_match = r_pend && (w_rdata == r_val);

    assign i_req.ready     = (r_state == osd_pkg::ST_IDLE);
    assign o_res.valid     = r_o_valid;
    assign o_res.kept      = r_o_kept;
    assign o_res.out_value = r_o_val;
    assign o_res.overflow  = r_o_ovf;

    // Next state and datapath control.
    always_comb begin
        n_state   = r_state;
        n_ex_cnt  = r_ex_cnt;
        n_pa_cnt  = r_pa_cnt;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_o_valid = r_o_valid;
        n_req     = r_req;
        n_val     = r_val;
        n_kept    = r_kept;
        n_ovf     = r_ovf;
        n_o_kept  = r_o_kept;
        n_o_val   = r_o_val;
        n_o_ovf   = r_o_ovf;
        w_ex_we   = 1'b0;
        w_pa_we   = 1'b0;

        // The output register empties when the downstream side takes the result.
        if (r_o_valid && o_res.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            osd_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.req_type;
                    n_val   = VALUE_WIDTH'(i_req.value);
                    n_state = osd_pkg::ST_EXEC;
                end
            end

            osd_pkg::ST_EXEC: begin
                n_kept = 1'b0;
                n_ovf  = 1'b0;
                case (r_req)
                    osd_pkg::REQ_CLEAR: begin
                        n_ex_cnt = '0;
                        n_pa_cnt = '0;
                        n_state  = osd_pkg::ST_FINISH;
                    end
                    osd_pkg::REQ_LOAD: begin
                        if (r_ex_cnt < ECW'(EXCLUDE_DEPTH)) begin
                            w_ex_we  = 1'b1;
                            n_ex_cnt = r_ex_cnt + ECW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_state = osd_pkg::ST_FINISH;
                    end
                    osd_pkg::REQ_TEST: begin
                        n_idx   = '0;
                        n_state = osd_pkg::ST_SCAN_EX;
                    end
                    default: begin
                        n_state = osd_pkg::ST_FINISH;
                    end
                endcase
            end

            osd_pkg::ST_SCAN_EX: begin
                if (w_match) begin
                    n_state = osd_pkg::ST_FINISH;
                end else if (r_idx < IW'(r_ex_cnt)) begin
                    n_idx  = r_idx + IW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_idx   = '0;
                    n_state = osd_pkg::ST_SCAN_PA;
                end
            end

            osd_pkg::ST_SCAN_PA: begin
                if (w_match) begin
                    n_state = osd_pkg::ST_FINISH;
                end else if (r_idx < IW'(r_pa_cnt)) begin
                    n_idx  = r_idx + IW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_state = osd_pkg::ST_APPEND;
                end
            end

            osd_pkg::ST_APPEND: begin
                // New and not excluded: pass it on, and remember it if there is room.
                n_kept = 1'b1;
                if (r_pa_cnt < PCW'(PASSED_DEPTH)) begin
                    w_pa_we  = 1'b1;
                    n_pa_cnt = r_pa_cnt + PCW'(1);
                end else begin
                    n_ovf = 1'b1;
                end
                n_state = osd_pkg::ST_FINISH;
            end

            osd_pkg::ST_FINISH: begin
                if (!r_o_valid || o_res.ready) begin
                    n_o_valid = 1'b1;
                    n_o_kept  = r_kept;
                    n_o_val   = r_kept ? OW'(r_val) : '0;
                    n_o_ovf   = r_ovf;
                    n_state   = osd_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = osd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= osd_pkg::ST_IDLE;
            r_ex_cnt  <= '0;
            r_pa_cnt  <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ex_cnt  <= n_ex_cnt;
            r_pa_cnt  <= n_pa_cnt;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_val    <= n_val;
        r_kept   <= n_kept;
        r_ovf    <= n_ovf;
        r_o_kept <= n_o_kept;
        r_o_val  <= n_o_val;
        r_o_ovf  <= n_o_ovf;
    end

    // The fill counts never pass the table depths.
    a_ex_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ex_cnt <= ECW'(EXCLUDE_DEPTH))
        else $error("excluded count beyond table depth");

    a_pa_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pa_cnt <= PCW'(PASSED_DEPTH))
        else $error("passed count beyond table depth");

    // A result that is not kept carries a zero value.
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.kept) |-> (o_res.out_value == '0))
        else $error("dropped result carries a value");

    // A kept result flagged as overflow can only come from a full passed table. It is
    // checked while the result is still in the sequencer, before a later clear can
    // empty the table under a stalled output register.
    a_kept_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == osd_pkg::ST_FINISH && r_kept && r_ovf)
            |-> (r_pa_cnt == PCW'(PASSED_DEPTH)))
        else $error("kept overflow while passed table has room");

    // An accepted transaction always moves the sequencer into execution.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == osd_pkg::ST_EXEC))
        else $error("accepted transaction not executed");

endmodule

@@ hw/rtl/osd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module osd_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the ordered set difference unit.
`timescale 1ns / 100ps

module tb_top;

    // Sizes used by the block under test and mirrored by the predictor below.
    localparam int EX_DEPTH    = osd_pkg::EXCLUDE_DEPTH_DEF;
    localparam int PA_DEPTH    = osd_pkg::PASSED_DEPTH_DEF;
    localparam int VAL_W       = osd_pkg::VALUE_WIDTH_DEF;
    localparam int PORT_W      = osd_pkg::VALUE_PORT_W;

    // The request code that the package leaves without a name; the block must ignore it.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Minimum number of random requests to generate after the directed opening.
    localparam int RANDOM_REQS = 800;

    // A test scans at most 128 entries, plus its execute, append and finish states. With roughly
    // 850 requests, the longest stalls on both sides and every test at its slowest,
    // a correct run stays far below this bound.
    localparam int CYCLE_LIMIT = 1000000;

    // Cycles to keep watching after the last expected result, to catch stray ones.
    localparam int DRAIN_CYCLES = 200;

    // Shapes of the random request sequences, each opened (usually) by a clear.
    typedef enum int {
        SESS_SHORT,
        SESS_EXCL_FILL,
        SESS_PASS_FILL
    } t_session;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PORT_W-1:0] value;
    } t_request;

    typedef struct packed {
        logic              kept;
        logic [PORT_W-1:0] out_value;
        logic              overflow;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n;

    osd_req_if req_if();
    osd_res_if res_if();

    ordered_set_difference_unit #(
        .EXCLUDE_DEPTH (EX_DEPTH),
        .PASSED_DEPTH  (PA_DEPTH),
        .VALUE_WIDTH   (VAL_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // 2 ns period: one nanosecond low, one high.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Requests waiting to be driven, and outcomes waiting to be seen on the result channel.
    t_request pending_reqs[$];
    t_outcome awaited_outcomes[$];

    // Predictor state: the two tables and their fill counts.
    logic [VAL_W-1:0] excluded_vals[EX_DEPTH];
    logic [VAL_W-1:0] passed_vals[PA_DEPTH];
    int               excluded_fill;
    int               passed_fill;

    // Bookkeeping for the closing summary and the pass/fail decision.
    int total_reqs;
    int accepted_reqs;
    int checked_results;
    int mismatches;
    int cycle_count;
    int n_clear, n_load, n_test, n_unused;
    int n_kept, n_excl_full, n_pass_full;

    // Works out the outcome of one request and updates the tables, just as the block
    // must. Only the low VAL_W bits of the value take part in storage and comparison.
    function automatic t_outcome apply_request(t_request rq);
        t_outcome         res;
        logic [VAL_W-1:0] cand;
        logic             seen;
        cand = rq.value[VAL_W-1:0];
        res  = '0;
        seen = 1'b0;
        case (rq.kind)
            osd_pkg::REQ_CLEAR: begin
                excluded_fill = 0;
                passed_fill   = 0;
                n_clear++;
            end
            osd_pkg::REQ_LOAD: begin
                n_load++;
                // A duplicate is stored again; a full table drops the value.
                if (excluded_fill < EX_DEPTH) begin
                    excluded_vals[excluded_fill] = cand;
                    excluded_fill++;
                end else begin
                    res.overflow = 1'b1;
                    n_excl_full++;
                end
            end
            osd_pkg::REQ_TEST: begin
                n_test++;
                for (int i = 0; i < excluded_fill; i++) begin
                    if (excluded_vals[i] == cand) seen = 1'b1;
                end
                for (int i = 0; i < passed_fill; i++) begin
                    if (passed_vals[i] == cand) seen = 1'b1;
                end
                if (!seen) begin
                    res.kept      = 1'b1;
                    res.out_value = PORT_W'(cand);
                    n_kept++;
                    // A new value is still passed on when the passed table is full,
                    // but it is not remembered, so it may be passed again later.
                    if (passed_fill < PA_DEPTH) begin
                        passed_vals[passed_fill] = cand;
                        passed_fill++;
                    end else begin
                        res.overflow = 1'b1;
                        n_pass_full++;
                    end
                end
            end
            default: begin
                // The unused code leaves the state alone and reports nothing.
                n_unused++;
            end
        endcase
        return res;
    endfunction

    // Idling pattern by progress through the stimulus: the first third has the
    // sender idle more lightly than the receiver, the second third the reverse,
    // and the last third runs with no idling on either side.
    function automatic int idle_phase();
        if (total_reqs == 0) return 0;
        return (accepted_reqs * 3) / total_reqs;
    endfunction

    task automatic push_req(logic [1:0] kind, logic [PORT_W-1:0] value);
        t_request rq;
        rq.kind  = kind;
        rq.value = value;
        pending_reqs = {pending_reqs, rq};
    endtask

    // Every input of the block is known from time zero; reset is held low at the start, then released.
    initial begin
        i_rst_n        = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = osd_pkg::REQ_CLEAR;
        req_if.value    = '0;
        res_if.ready    = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Request driver. A new transaction is offered only when the channel is empty or
    // the current one is being accepted at this edge, so valid is never dropped and
    // raised again within one time step. Each accepted request is fed to the
    // predictor at the edge where the handshake completes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                awaited_outcomes = {awaited_outcomes,
                                    apply_request('{kind:  req_if.req_type,
                                                    value: req_if.value})};
                accepted_reqs++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() != 0 &&
                    $urandom_range(99) >= (idle_phase() == 0 ? 34 :
                                           idle_phase() == 1 ? 46 : 0)) begin
                    req_if.valid    <= 1'b1;
                    req_if.req_type <= pending_reqs[0].kind;
                    req_if.value    <= pending_reqs[0].value;
                    void'(pending_reqs.pop_front());
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each accepted result is checked field by field against the
    // oldest outstanding prediction; ready is then redrawn for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (awaited_outcomes.size() == 0) begin
                $error("Result with no request outstanding: kept %0d, out_value %h, overflow %0d",
                       res_if.kept, res_if.out_value, res_if.overflow);
                mismatches++;
            end else begin
                t_outcome want;
                want = awaited_outcomes.pop_front();
                checked_results++;
                if (res_if.kept !== want.kept) begin
                    $error("kept: expected %0d, actual %0d", want.kept, res_if.kept);
                    mismatches++;
                end
                if (res_if.out_value !== want.out_value) begin
                    $error("out_value: expected %h, actual %h", want.out_value,
                           res_if.out_value);
                    mismatches++;
                end
                if (res_if.overflow !== want.overflow) begin
                    $error("overflow: expected %0d, actual %0d", want.overflow,
                           res_if.overflow);
                    mismatches++;
                end
            end
        end
        res_if.ready <= ($urandom_range(99) >= (idle_phase() == 0 ? 46 :
                                                idle_phase() == 1 ? 34 : 0));
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                     awaited_outcomes.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [PORT_W-1:0] pool[$];
        t_session          shape;
        int                n_loads;
        int                n_tests;
        int                pool_n;
        int                session_idx;
        logic [PORT_W-1:0] v;

        excluded_fill   = 0;
        passed_fill     = 0;
        accepted_reqs   = 0;
        checked_results = 0;
        mismatches      = 0;
        cycle_count     = 0;
        total_reqs      = 0;
        {n_clear, n_load, n_test, n_unused} = '0;
        {n_kept, n_excl_full, n_pass_full}  = '0;

        // Directed opening: value extremes, every request code, the repeat and the
        // exclusion paths, and the unused code leaving the tables untouched.
        push_req(osd_pkg::REQ_CLEAR, 32'hFFFF_FFFF);   // value is ignored on a clear
        push_req(osd_pkg::REQ_TEST,  32'h0000_0000);   // empty tables: kept
        push_req(osd_pkg::REQ_TEST,  32'h0000_0000);   // already passed: dropped
        push_req(osd_pkg::REQ_TEST,  32'hFFFF_FFFF);
        push_req(osd_pkg::REQ_LOAD,  32'hFFFF_FFFF);
        push_req(osd_pkg::REQ_LOAD,  32'hFFFF_FFFF);   // duplicate load is stored again
        push_req(osd_pkg::REQ_TEST,  32'h1234_5678);
        push_req(osd_pkg::REQ_LOAD,  32'h0000_0001);
        push_req(osd_pkg::REQ_TEST,  32'h0000_0001);   // excluded
        push_req(REQ_UNUSED,         32'hDEAD_BEEF);
        push_req(osd_pkg::REQ_TEST,  32'hDEAD_BEEF);   // unused code must not have stored it
        push_req(REQ_UNUSED,         32'h0000_0000);
        push_req(osd_pkg::REQ_CLEAR, 32'h0000_0000);
        push_req(osd_pkg::REQ_TEST,  32'hFFFF_FFFF);   // kept again once the tables are cleared
        push_req(osd_pkg::REQ_LOAD,  32'h8000_0000);
        push_req(osd_pkg::REQ_TEST,  32'h8000_0000);
        push_req(osd_pkg::REQ_TEST,  32'h7FFF_FFFF);
        push_req(osd_pkg::REQ_TEST,  32'hAAAA_AAAA);
        push_req(osd_pkg::REQ_TEST,  32'h5555_5555);
        push_req(osd_pkg::REQ_TEST,  32'h7FFF_FFFF);
        push_req(osd_pkg::REQ_TEST,  32'h1234_5678);   // earlier pass was forgotten by the clear

        // Random part: mostly well-formed sessions (clear, loads, then tests drawn
        // from a small pool so that exclusions and repeats are frequent), with a
        // sprinkling of unused codes, stray loads and fresh random candidates.
        // The first two sessions take the shapes meant to fill the excluded and the passed
        // table respectively, to drive both overflow paths early in the run.
        session_idx = 0;
        while (pending_reqs.size() < RANDOM_REQS + 21) begin
            if (session_idx == 0) begin
                shape = SESS_EXCL_FILL;
            end else if (session_idx == 1) begin
                shape = SESS_PASS_FILL;
            end else begin
                case ($urandom_range(99) / 10)
                    0:       shape = SESS_EXCL_FILL;
                    1:       shape = ($urandom_range(1) != 0) ? SESS_PASS_FILL : SESS_SHORT;
                    default: shape = SESS_SHORT;
                endcase
            end
            session_idx++;

            // Now and then the tables carry over from the previous session.
            if ($urandom_range(99) < 90) push_req(osd_pkg::REQ_CLEAR, $urandom);

            case (shape)
                SESS_EXCL_FILL: begin
                    n_loads = $urandom_range(70, 62);
                    pool_n  = $urandom_range(12, 4);
                    n_tests = $urandom_range(20, 8);
                end
                SESS_PASS_FILL: begin
                    n_loads = $urandom_range(4, 0);
                    pool_n  = $urandom_range(80, 66);
                    n_tests = pool_n + $urandom_range(12, 0);
                end
                default: begin
                    n_loads = $urandom_range(8, 0);
                    pool_n  = $urandom_range(12, 1);
                    n_tests = $urandom_range(16, 1);
                end
            endcase

            pool.delete();
            repeat (pool_n) pool = {pool, PORT_W'($urandom)};

            for (int i = 0; i < n_loads; i++) begin
                if (shape == SESS_EXCL_FILL)
                    v = ($urandom_range(3) == 0) ? pool[$urandom_range(pool_n - 1)] : $urandom;
                else
                    v = ($urandom_range(1) == 0) ? pool[$urandom_range(pool_n - 1)] : $urandom;
                push_req(osd_pkg::REQ_LOAD, v);
            end

            for (int i = 0; i < n_tests; i++) begin
                // Filling the passed table walks the pool in order first, so that it
                // really sees more distinct candidates than it can hold; the tail
                // then repeats values, some of which were passed but not remembered.
                if (shape == SESS_PASS_FILL && i < pool_n)
                    v = pool[i];
                else if ($urandom_range(99) < 15)
                    v = $urandom;
                else
                    v = pool[$urandom_range(pool_n - 1)];
                push_req(osd_pkg::REQ_TEST, v);

                case ($urandom_range(99))
                    0, 1, 2, 3: push_req(REQ_UNUSED, $urandom);
                    4, 5, 6:    push_req(osd_pkg::REQ_LOAD, pool[$urandom_range(pool_n - 1)]);
                    default:    ;
                endcase
            end
        end
        total_reqs = pending_reqs.size();

        // Wait for every request to be taken and every outcome to be seen, then give
        // the block time to show any result it should not produce.
        while (pending_reqs.size() != 0 || req_if.valid || awaited_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d clears, %0d loads, %0d tests, %0d unused codes.",
                 accepted_reqs, n_clear, n_load, n_test, n_unused);
        $display("%0d candidates kept; excluded table full %0d times, passed table full %0d times.",
                 n_kept, n_excl_full, n_pass_full);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/osd_pkg.sv
hw/rtl/osd_req_if.sv
hw/rtl/osd_res_if.sv
hw/rtl/osd_ram.sv
hw/rtl/ordered_set_difference_unit.sv
sim/tb_top.sv
